>>> rtl/core/luminance_integrate_line_marker_defines.svh
// Assertion macros for the luminance line marker RTL.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef LUMINANCE_INTEGRATE_LINE_MARKER_DEFINES_SVH
`define LUMINANCE_INTEGRATE_LINE_MARKER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LILM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define LILM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/lilm_pkg.sv
// Package for the luminance line marker: register indexes, widths, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lilm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ON   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_OFF  = 3'd7;

    localparam int unsigned GAIN_W  = 11;
    localparam int unsigned THR_W   = 17;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned ACC_W   = 19;
    localparam int unsigned STEP_W  = 9;   // gray or 256 - gray
    localparam int unsigned PROD_W  = STEP_W + GAIN_W;

    // floor(x / 3) == (x * 683) >> 11 for x in 0..765
    localparam logic [9:0]  DIV3_MUL   = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    localparam logic [GAIN_W-1:0] GAIN_RST      = 11'd256;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 17'd32768;
    localparam logic [7:0]        ALPHA_ON_RST  = 8'd255;
    localparam logic [7:0]        ALPHA_OFF_RST = 8'd0;
    localparam logic [7:0]        LEVEL_WHITE   = 8'd255;
    localparam logic [7:0]        LEVEL_BLACK   = 8'd0;
    localparam logic [ACC_W-1:0]  ACC_MAX       = '1;

endpackage

`default_nettype wire

>>> rtl/core/luminance_integrate_line_marker.sv
// Luminance line marker: input then output register; 1 pixel per cycle unless stalled.
// Throughput is set by the accumulator feedback: one multiply, add, saturate and compare
// per cycle in the second stage. Synchronous active-low reset clears both stage valids,
// the accumulator and dash/gap counters, and loads register reset values.
// Depends on lilm_pkg and luminance_integrate_line_marker_defines.svh.
// Stalls are absorbed by the input register and the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "luminance_integrate_line_marker_defines.svh"

module luminance_integrate_line_marker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lilm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lilm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel in
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [23:0]                        i_s_axis_tdata,  // red, green, blue
    input  wire logic                               i_s_axis_tuser,  // line_start
    // pixel out
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [15:0]                             o_m_axis_tdata   // alpha, level
);
    import lilm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] r_gain;
    logic [THR_W-1:0]  r_threshold;
    logic [CNT_W-1:0]  r_dash_count;
    logic [CNT_W-1:0]  r_gap_count;
    logic [CNT_W-1:0]  r_mark_width;
    logic              r_invert;
    logic [7:0]        r_alpha_on;
    logic [7:0]        r_alpha_off;

    // Always ready; host must write only while the pixel path is idle; not enforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RST;
            r_threshold  <= THRESHOLD_RST;
            r_dash_count <= '0;
            r_gap_count  <= '0;
            r_mark_width <= '0;
            r_invert     <= 1'b0;
            r_alpha_on   <= ALPHA_ON_RST;
            r_alpha_off  <= ALPHA_OFF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN:       r_gain       <= i_cfg_data[GAIN_W-1:0];
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                REG_DASH_COUNT: r_dash_count <= i_cfg_data[CNT_W-1:0];
                REG_GAP_COUNT:  r_gap_count  <= i_cfg_data[CNT_W-1:0];
                REG_MARK_WIDTH: r_mark_width <= i_cfg_data[CNT_W-1:0];
                REG_INVERT:     r_invert     <= i_cfg_data[0];
                REG_ALPHA_ON:   r_alpha_on   <= i_cfg_data[7:0];
                REG_ALPHA_OFF:  r_alpha_off  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake / stage control ----------------
    logic r_v1;        // input register holds a pixel
    logic r_ov;        // output register holds a result
    logic w_out_free;  // output register can take a result this cycle
    logic w_adv;       // stage-1 pixel moves into the output register
    logic w_acc_in;    // new pixel request accepted

    assign w_out_free      = !r_ov || i_m_axis_tready;
    assign w_adv           = r_v1 && w_out_free;
    assign o_s_axis_tready = !r_v1 || w_adv;
    assign w_acc_in        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_out_free) begin
                r_ov <= r_v1;
            end
        end
    end

    // ---------------- stage 1: gray and step value ----------------
    // gray = floor((r+g+b)/3) by reciprocal multiply; step = gray or 256-gray.
    logic [9:0]        w_chan_sum;
    logic [19:0]       w_div_prod;
    logic [7:0]        w_gray;
    logic [STEP_W-1:0] w_step;
    logic [STEP_W-1:0] r_step;
    logic              r_line_start;

    assign w_chan_sum = {2'b00, i_s_axis_tdata[7:0]} + {2'b00, i_s_axis_tdata[15:8]}
                      + {2'b00, i_s_axis_tdata[23:16]};
    assign w_div_prod = {10'd0, w_chan_sum} * {10'd0, DIV3_MUL};
    assign w_gray     = w_div_prod[DIV3_SHIFT +: 8];
    assign w_step     = r_invert ? {1'b0, w_gray} : (9'd256 - {1'b0, w_gray});

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_step       <= w_step;
            r_line_start <= i_s_axis_tuser;
        end
    end

    // ---------------- stage 2: accumulate, trigger, dash/gap machine ----------------
    logic [ACC_W-1:0] r_accum;
    logic [CNT_W-1:0] r_draw_left;
    logic [CNT_W-1:0] r_dashes_left;
    logic [CNT_W-1:0] r_gap_left;

    logic [ACC_W-1:0]  w_acc0;
    logic [CNT_W-1:0]  w_draw0, w_dash0, w_gap0;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_sum;
    logic [ACC_W-1:0]  w_sat;
    logic              w_trig;
    logic [CNT_W-1:0]  w_draw1, w_dash1, w_gap1;
    logic              w_marked;

    logic [ACC_W-1:0] n_accum;
    logic [CNT_W-1:0] n_draw_left;

    always_comb begin
        // line start clears accumulator, draw and gap counts and reloads the dash count before the pixel is used
        w_acc0  = r_line_start ? '0 : r_accum;
        w_draw0 = r_line_start ? '0 : r_draw_left;
        w_dash0 = r_line_start ? r_dash_count : r_dashes_left;
        w_gap0  = r_line_start ? '0 : r_gap_left;

        w_prod = {{GAIN_W{1'b0}}, r_step} * {{STEP_W{1'b0}}, r_gain};
        w_sum  = {{(PROD_W + 1 - ACC_W){1'b0}}, w_acc0} + {1'b0, w_prod};
        w_sat  = (w_sum > {{(PROD_W + 1 - ACC_W){1'b0}}, ACC_MAX}) ? ACC_MAX
                                                                  : w_sum[ACC_W-1:0];
        w_trig = w_sat >= {{(ACC_W - THR_W){1'b0}}, r_threshold};

        w_draw1 = w_draw0;
        w_dash1 = w_dash0;
        w_gap1  = w_gap0;
        if (w_trig) begin
            priority if (w_gap0 == '0 && w_dash0 == '0) begin
                w_dash1 = r_dash_count;
                w_gap1  = r_gap_count;
            end else if (w_gap0 == '0) begin
                w_draw1 = r_mark_width;
                w_dash1 = w_dash0 - 1'b1;
            end else begin
                w_gap1 = w_gap0 - 1'b1;
            end
        end

        w_marked    = w_draw1 != '0;
        n_accum     = w_trig ? '0 : w_sat;
        n_draw_left = w_marked ? (w_draw1 - 1'b1) : w_draw1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum       <= '0;
            r_draw_left   <= '0;
            r_dashes_left <= '0;   // dash_count reset value
            r_gap_left    <= '0;
        end else if (w_adv) begin
            r_accum       <= n_accum;
            r_draw_left   <= n_draw_left;
            r_dashes_left <= w_dash1;
            r_gap_left    <= w_gap1;
        end
    end

    // ---------------- output register ----------------
    logic [7:0] r_level;
    logic [7:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_level <= w_marked ? LEVEL_WHITE : LEVEL_BLACK;
            r_alpha <= w_marked ? r_alpha_on : r_alpha_off;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_alpha, r_level};

    // ---------------- assertions ----------------
    // Input side only stalls while a pixel waits in stage 1.
    `LILM_ASSERT_NOW(a_stall_has_item, !o_s_axis_tready, r_v1)
    // A trigger always clears the accumulator.
    `LILM_ASSERT_NEXT(a_trig_clears, w_adv && w_trig, r_accum == '0)
    // Line state only moves when a pixel advances.
    `LILM_ASSERT_NEXT(a_state_hold, !w_adv, $stable(r_accum) && $stable(r_draw_left))
    // A pixel leaving stage 1 always produces a result.
    `LILM_ASSERT_NEXT(a_adv_result, w_adv, r_ov)

endmodule

`default_nettype wire
